@@ design/ppdpt_pkg.sv @@
// Shared types, phase codes, register indexes and reset values
// for the pedal phase-delay pulse trigger. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppdpt_pkg;

  // Millisecond counter width
  localparam int TimeW = 8;
  localparam int CfgIdxW = 4;
  localparam int CfgDataW = 8;

  // Phase codes
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_DEBOUNCE = 3'd1;
  localparam logic [2:0] PH_SETTLE   = 3'd2;
  localparam logic [2:0] PH_WAITZERO = 3'd3;
  localparam logic [2:0] PH_DELAY    = 3'd4;
  localparam logic [2:0] PH_FIRE     = 3'd5;
  localparam logic [2:0] PH_RELEASE  = 3'd6;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE  = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_DELAY = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DELAY = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_PULSE     = 4'd3;

  // Register reset values
  localparam logic [7:0] RST_DEBOUNCE  = 8'd100;
  localparam logic [7:0] RST_MIN_DELAY = 8'd3;
  localparam logic [7:0] RST_MAX_DELAY = 8'd5;
  localparam logic [7:0] RST_PULSE     = 8'd1;

  typedef struct packed {
    logic       pedal_level;
    logic       comparator_out;
    logic [7:0] knob_value;
    logic       ms_strobe;
  } in_item_t;

  typedef struct packed {
    logic       fire_level;
    logic [2:0] phase;
  } out_item_t;

  typedef struct packed {
    logic [7:0] debounce_ms;
    logic [7:0] min_delay_ms;
    logic [7:0] max_delay_ms;
    logic [7:0] pulse_ms;
  } cfg_t;

endpackage

`default_nettype wire

@@ design/pedal_phase_delay_pulse_trigger.sv @@
// Top level of the pedal phase-delay pulse trigger: beat registers and handshakes.
// Depends on ppdpt_pkg, ppdpt_cfg_regs and ppdpt_core.
//
//   port group | dir | handshake           | beat payload
//   in_*       | in  | in_valid / in_stall   | in_item_t  (pedal, comparator, knob, strobe)
//   out_*      | out | out_valid / out_stall | out_item_t (fire level, phase)
//   cfg_*      | in  | cfg_valid / cfg_ready | register index, 8-bit write data
//
// One beat per clock sustained while out_stall is low; each input beat yields
// exactly one result beat. An accepted beat passes the input register, then the
// phase logic into the result register, before the result is offered. The phase
// state updates in the same cycle as the result register loads, so consecutive
// beats chain without bubbles.
// Reset (synchronous, rst_n low) empties both beat registers, sets the phase to
// idle and loads the register defaults. A stalled result holds in place; a new
// input beat still enters while the input register is free.
`timescale 1ns / 1ps
`default_nettype none

module pedal_phase_delay_pulse_trigger
  import ppdpt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input beats
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_data,
  // result beats
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data,
  // register writes
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  s1_data_r;
  logic      s1_valid_r, s1_valid_nxt;
  out_item_t out_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t result;
  logic      in_take;
  logic      adv;

  // Registers always take writes
  assign cfg_ready = 1'b1;

  ppdpt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // Advance the held beat when the result register is empty or draining
  assign adv      = s1_valid_r & ~(out_valid_r & out_stall);
  assign in_stall = s1_valid_r & ~adv;
  assign in_take  = in_valid & ~in_stall;

  ppdpt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (s1_data_r),
    .cfg    (cfg),
    .result (result)
  );

  always_comb begin
    // hold the input beat until it advances; refill on a new accept
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    // result stays until taken
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Fire output tracks the fire phase in every delivered beat
  a_fire_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.fire_level == (out_data_r.phase == PH_FIRE)))
    else $error("fire level disagrees with phase");

  // Unused phase code never leaves the block
  a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.phase <= PH_RELEASE))
    else $error("phase code out of range");

  // Input stalls only when both beat registers are occupied
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room available");

  // An advanced beat always lands in the result register
  a_adv_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced beat lost");

endmodule

`default_nettype wire

@@ design/ppdpt_cfg_regs.sv @@
// Configuration register file for the pedal trigger.
// Depends on ppdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppdpt_cfg_regs
  import ppdpt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire logic [CfgIdxW-1:0]  wr_index,
  input  wire logic [CfgDataW-1:0] wr_data,
  output cfg_t                     cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_DEBOUNCE:  cfg_nxt.debounce_ms  = wr_data;
        CFG_MIN_DELAY: cfg_nxt.min_delay_ms = wr_data;
        CFG_MAX_DELAY: cfg_nxt.max_delay_ms = wr_data;
        CFG_PULSE:     cfg_nxt.pulse_ms     = wr_data;
        default:       cfg_nxt = cfg_r; // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms  <= RST_DEBOUNCE;
      cfg_r.min_delay_ms <= RST_MIN_DELAY;
      cfg_r.max_delay_ms <= RST_MAX_DELAY;
      cfg_r.pulse_ms     <= RST_PULSE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ design/ppdpt_delay_calc.sv @@
// Knob-scaled delay: min + knob*(max-min)/255, clamped to min when max < min.
// Depends on ppdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppdpt_delay_calc
  import ppdpt_pkg::*;
(
  input  wire logic [7:0] knob,
  input  wire cfg_t       cfg,
  output logic [7:0]      delay
);

  logic [7:0]  span;
  logic [15:0] prod;
  logic [16:0] q_sum;
  logic [7:0]  quot;
  logic [8:0]  total;

  always_comb begin
    span  = cfg.max_delay_ms - cfg.min_delay_ms;
    prod  = 16'(knob) * 16'(span);
    // divide by 255: (x + (x >> 8) + 1) >> 8 is exact for x <= 255*255
    q_sum = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    quot  = q_sum[15:8];
    total = 9'(cfg.min_delay_ms) + 9'(quot);
    if (cfg.max_delay_ms < cfg.min_delay_ms) begin
      delay = cfg.min_delay_ms;
    end else begin
      delay = total[7:0];
    end
  end

endmodule

`default_nettype wire

@@ design/ppdpt_core.sv @@
// Phase sequencer: debounce, settle, zero-cross wait, delay, fire, release.
// Depends on ppdpt_pkg and ppdpt_delay_calc.
`timescale 1ns / 1ps
`default_nettype none

module ppdpt_core
  import ppdpt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     result
);

  logic [2:0]       phase_r, phase_nxt;
  logic [TimeW-1:0] ms_count_r, ms_count_nxt;
  logic             clean_r, clean_nxt;
  logic [7:0]       delay_target_r, delay_target_nxt;

  logic [7:0]       delay_calc;
  logic [TimeW-1:0] cnt_inc;
  logic             clean_win;
  logic             win_done;

  ppdpt_delay_calc u_delay (
    .knob  (item.knob_value),
    .cfg   (cfg),
    .delay (delay_calc)
  );

  always_comb begin
    cnt_inc   = ms_count_r + TimeW'(item.ms_strobe);
    clean_win = clean_r & item.pedal_level;
    win_done  = (cnt_inc >= TimeW'(cfg.debounce_ms));

    phase_nxt        = phase_r;
    ms_count_nxt     = ms_count_r;
    clean_nxt        = clean_r;
    delay_target_nxt = delay_target_r;

    unique case (phase_r)
      PH_IDLE: begin
        if (item.pedal_level) begin
          phase_nxt    = PH_DEBOUNCE;
          ms_count_nxt = '0;
          clean_nxt    = 1'b1;
        end
      end
      PH_DEBOUNCE: begin
        clean_nxt    = clean_win;
        ms_count_nxt = cnt_inc;
        if (win_done) begin
          phase_nxt    = clean_win ? PH_SETTLE : PH_IDLE;
          ms_count_nxt = '0;
        end
      end
      PH_SETTLE: begin
        if (item.ms_strobe) begin
          phase_nxt = PH_WAITZERO;
        end
      end
      PH_WAITZERO: begin
        if (!item.comparator_out) begin
          delay_target_nxt = delay_calc;
          phase_nxt        = PH_DELAY;
          ms_count_nxt     = '0;
        end
      end
      PH_DELAY: begin
        ms_count_nxt = cnt_inc;
        if (cnt_inc >= TimeW'(delay_target_r)) begin
          phase_nxt    = PH_FIRE;
          ms_count_nxt = '0;
        end
      end
      PH_FIRE: begin
        ms_count_nxt = cnt_inc;
        if (cnt_inc >= TimeW'(cfg.pulse_ms)) begin
          phase_nxt    = PH_RELEASE;
          ms_count_nxt = '0;
          clean_nxt    = 1'b1;
        end
      end
      PH_RELEASE: begin
        if (!item.pedal_level && (ms_count_r == '0) && clean_r) begin
          // released before the first strobe of the window
          phase_nxt = PH_IDLE;
          clean_nxt = 1'b0;
        end else begin
          clean_nxt    = clean_win;
          ms_count_nxt = cnt_inc;
          if (win_done) begin
            ms_count_nxt = '0;
            if (!clean_win) begin
              phase_nxt = PH_IDLE;
            end
          end
        end
      end
      default: begin
        phase_nxt    = PH_IDLE;
        ms_count_nxt = '0;
        clean_nxt    = 1'b0;
      end
    endcase

    result.fire_level = (phase_nxt == PH_FIRE);
    result.phase      = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      ms_count_r     <= '0;
      clean_r        <= 1'b0;
      delay_target_r <= '0;
    end else if (adv) begin
      phase_r        <= phase_nxt;
      ms_count_r     <= ms_count_nxt;
      clean_r        <= clean_nxt;
      delay_target_r <= delay_target_nxt;
    end
  end

endmodule

`default_nettype wire
